FILE: src/esms_pkg.sv
// Package for the exact sequence match stream block.
// Holds beat structs, register indexes, widths and cell control type.
// No dependencies.
`default_nettype none
package esms_pkg;

	localparam int MAX_PATTERN   = 16;
	localparam int POSITION_BITS = 32;
	localparam int CHAR_BITS     = 8;
	localparam int COUNT_BITS    = 32;
	localparam int LEN_BITS      = 5;
	localparam int LEN_IDX_BITS  = $clog2(MAX_PATTERN) > 0 ? $clog2(MAX_PATTERN) : 1;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_PAT_LO   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAT_HI   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAT_LEN  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_STOP_1ST = 3'd3;

	// result kinds
	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [CHAR_BITS-1:0] text_char;
		logic                 end_of_text;
	} in_beat_t;

	typedef struct packed {
		logic                  result_kind;
		logic [31:0]           match_start;
		logic [COUNT_BITS-1:0] match_total;
		logic                  last_of_run;
	} out_beat_t;

	// control shared by every cell of the window
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/esms_cell.sv
// One window cell: holds one history character and its compare flag.
// Depends on esms_pkg.
`default_nettype none
module esms_cell (
	input  wire                            clk,
	input  wire                            arst_n,
	input  esms_pkg::cell_ctrl_t           ctrl,
	input  wire  [esms_pkg::CHAR_BITS-1:0] d_in,
	input  wire  [esms_pkg::CHAR_BITS-1:0] pchar,
	input  wire                            care,
	output logic [esms_pkg::CHAR_BITS-1:0] char_q,
	output logic                           hit_s1
);
	import esms_pkg::*;

	// take the neighbor's character (zero on clear); flag whether it agrees with the pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= '0;
			hit_s1 <= 1'b0;
		end else if (ctrl.shift) begin
			char_q <= ctrl.clear ? '0 : d_in;
			hit_s1 <= care ? (d_in == pchar) : 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: src/esms_result_fifo.sv
// Small result queue: up to two beats written per cycle, one read.
// Depends on esms_pkg.
`default_nettype none
module esms_result_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [1:0]          wr_cnt,
	input  esms_pkg::out_beat_t wr_data0,
	input  esms_pkg::out_beat_t wr_data1,
	output logic                room2,
	output logic                out_valid,
	input  wire                 out_stall,
	output esms_pkg::out_beat_t out_data
);
	import esms_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	out_beat_t           mem [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   count_q;
	logic                pop;
	logic [PTR_BITS-1:0] wr_ptr_nx;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign out_data  = mem[rd_ptr_q];
	assign room2     = (count_q <= (PTR_BITS+1)'(DEPTH - 2));
	assign wr_ptr_nx = wr_ptr_q + PTR_BITS'(1);

	// storage, no reset
	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0)
			mem[wr_ptr_q] <= wr_data0;
		if (wr_cnt == 2'd2)
			mem[wr_ptr_nx] <= wr_data1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(wr_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			count_q <= count_q + (PTR_BITS+1)'(wr_cnt) - (PTR_BITS+1)'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: src/exact_sequence_match_stream_core.sv
// Streaming exact pattern matcher, one text character per cycle while in_stall is low.
// An accepted beat is compared into the cells' registered hit flags, then
// resolved into the result queue once it has room and shown on out_data.
// Output runs one beat per cycle while out_stall is low, so a character giving
// both a match and a summary takes one extra output beat.
// Reset clears history, position, counts and queue; config takes its defaults.
`default_nettype none
module exact_sequence_match_stream_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  esms_pkg::in_beat_t                 in_data,
	output logic                               out_valid,
	input  wire                                out_stall,
	output esms_pkg::out_beat_t                out_data,
	input  wire                                cfg_we,
	input  wire  [esms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire  [esms_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import esms_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
	localparam logic [COUNT_BITS-1:0]    COUNT_MAX = '1;

	// configuration registers
	logic [63:0]         pat_lo_q;
	logic [63:0]         pat_hi_q;
	logic [LEN_BITS-1:0] pat_len_q;
	logic                stop_q;

	// per-text state
	logic [POSITION_BITS-1:0] pos_q;
	logic [COUNT_BITS-1:0]    matches_q;
	logic                     first_found_q;

	// stage 1 item
	logic        s1_valid_q;
	logic        window_ok_s1;
	logic        last_s1;
	logic [31:0] start_s1;

	logic                    accept;
	logic                    advance;
	logic                    room2;
	logic [LEN_IDX_BITS-1:0] len_m1;
	logic [CHAR_BITS-1:0]    pat [MAX_PATTERN];
	logic [CHAR_BITS-1:0]    hist [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]  hit_vec;
	cell_ctrl_t              cell_ctrl;
	logic                    hit;
	logic [COUNT_BITS-1:0]   matches_nx;
	logic [1:0]              wr_cnt;
	out_beat_t               match_beat;
	out_beat_t               summary_beat;
	out_beat_t               wr_data0;
	out_beat_t               wr_data1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_BITS'(1);
			stop_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_LO:   pat_lo_q  <= cfg_wdata;
				REG_PAT_HI:   pat_hi_q  <= cfg_wdata;
				REG_PAT_LEN:  pat_len_q <= cfg_wdata[LEN_BITS-1:0];
				REG_STOP_1ST: stop_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// clamp length to 1..MAX_PATTERN, kept as length minus one
	always_comb begin
		if (pat_len_q == '0)
			len_m1 = '0;
		else if (pat_len_q > LEN_BITS'(MAX_PATTERN))
			len_m1 = LEN_IDX_BITS'(MAX_PATTERN - 1);
		else
			len_m1 = LEN_IDX_BITS'(pat_len_q - LEN_BITS'(1));
	end

	// unpack pattern bytes
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i < 8)
				pat[i] = pat_lo_q[(i%8)*8 +: 8];
			else
				pat[i] = pat_hi_q[(i%8)*8 +: 8];
		end
	end

	// handshake
	assign in_stall = s1_valid_q && !room2;
	assign accept   = in_valid && !in_stall;
	assign advance  = s1_valid_q && room2;

	assign cell_ctrl.shift = accept;
	assign cell_ctrl.clear = accept && in_data.end_of_text;

	// window: cell k holds history entry k, compared with pattern char len-1-k
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [LEN_IDX_BITS-1:0] pidx;
		logic                    care;
		logic [CHAR_BITS-1:0]    d_in;

		assign pidx = len_m1 - LEN_IDX_BITS'(k);
		assign care = (LEN_IDX_BITS'(k) <= len_m1);
		if (k == 0) begin : g_head
			assign d_in = in_data.text_char;
		end else begin : g_link
			assign d_in = hist[k-1];
		end

		esms_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.d_in   (d_in),
			.pchar  (pat[pidx]),
			.care   (care),
			.char_q (hist[k]),
			.hit_s1 (hit_vec[k])
		);
	end

	// position counter and stage 1 side data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (in_data.end_of_text)
					pos_q <= '0;
				else if (pos_q != POS_MAX)
					pos_q <= pos_q + POSITION_BITS'(1);
			end
			if (accept)
				s1_valid_q <= 1'b1;
			else if (advance)
				s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_ok_s1 <= (pos_q >= POSITION_BITS'(len_m1));
			last_s1      <= in_data.end_of_text;
			start_s1     <= 32'(pos_q - POSITION_BITS'(len_m1));
		end
	end

	// resolve the match and update per-text counts
	assign hit = (&hit_vec) && window_ok_s1 && !(stop_q && first_found_q);
	assign matches_nx = (hit && matches_q != COUNT_MAX) ?
		matches_q + COUNT_BITS'(1) : matches_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matches_q     <= '0;
			first_found_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				matches_q     <= '0;
				first_found_q <= 1'b0;
			end else begin
				matches_q     <= matches_nx;
				first_found_q <= first_found_q || hit;
			end
		end
	end

	// result beats for this item
	always_comb begin
		match_beat.result_kind   = KIND_MATCH;
		match_beat.match_start   = start_s1;
		match_beat.match_total   = matches_nx;
		match_beat.last_of_run   = !last_s1;
		summary_beat.result_kind = KIND_SUMMARY;
		summary_beat.match_start = '0;
		summary_beat.match_total = matches_nx;
		summary_beat.last_of_run = 1'b1;

		wr_data0 = hit ? match_beat : summary_beat;
		wr_data1 = summary_beat;
		if (!advance)
			wr_cnt = 2'd0;
		else
			wr_cnt = 2'(hit) + 2'(last_s1);
	end

	esms_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_cnt    (wr_cnt),
		.wr_data0  (wr_data0),
		.wr_data1  (wr_data1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
